>>> rtl/lbcg_pkg.sv
package lbcg_pkg;

  localparam int PHASE_BITS_DEF     = 16;
  localparam int COS_TABLE_BITS_DEF = 8;

  localparam int NOW_W     = 32;
  localparam int DT_W      = 16;
  localparam int HALF_W    = 15;
  localparam int LEVEL_W   = 8;
  localparam int IVAL_W    = 10;
  localparam int EASE_W    = 16;
  localparam int MAG_W     = 17;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [HALF_W-1:0] HALF_MIN = HALF_W'(200);
  localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(20000);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(255);

  localparam logic [HALF_W-1:0]  HALF_RST  = HALF_W'(2000);
  localparam logic [LEVEL_W-1:0] LVL_A_RST = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LVL_B_RST = LEVEL_W'(255);
  localparam logic [LEVEL_W-1:0] BASE_RST  = LEVEL_W'(255);
  localparam logic [IVAL_W-1:0]  IVAL_RST  = IVAL_W'(10);

  // Odd sine polynomial coefficients, Q2.30
  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd693598674;
  localparam logic [63:0] SIN_C = 64'd85569306;
  localparam logic [63:0] SIN_D = 64'd5026996;
  localparam logic [63:0] SIN_E = 64'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD = 3'd0,
    REG_LEVEL_A     = 3'd1,
    REG_LEVEL_B     = 3'd2,
    REG_BASE_RED    = 3'd3,
    REG_BASE_GREEN  = 3'd4,
    REG_BASE_BLUE   = 3'd5,
    REG_RUN_ENABLE  = 3'd6,
    REG_INTERVAL    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EASE,
    ST_SQUARE,
    ST_CUBE,
    ST_SPAN,
    ST_COLOR_GO,
    ST_COLOR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] out_red;
    logic [LEVEL_W-1:0] out_green;
    logic [LEVEL_W-1:0] out_blue;
    logic [LEVEL_W-1:0] level;
  } out_res_t;

  // Quarter-wave sine table entry in Q16, evaluated at elaboration
  function automatic logic [MAG_W-1:0] quarter_sine(input int j, input int ctb);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    u  = 64'(j) << (30 - ctb);
    u2 = (u * u) >> 30;
    t  = SIN_E;
    t  = SIN_D - ((u2 * t) >> 30);
    t  = SIN_C - ((u2 * t) >> 30);
    t  = SIN_B - ((u2 * t) >> 30);
    t  = SIN_A - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s[MAG_W-1:0];
  endfunction

  // floor(p / 255) for p up to 255*255, by reciprocal with correction
  function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] p);
    logic [2*LEVEL_W:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> rtl/lbcg_stream_if.sv
interface lbcg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lbcg_serial_mul.sv
module lbcg_serial_mul import lbcg_pkg::*; #(
  parameter int A_W = EASE_W,
  parameter int B_W = EASE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int STEPS = B_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] p_r;
  logic [A_W+B_W-1:0] p_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [A_W+1:0]     part;
  logic [A_W+1:0]     sum;

  // Radix-4 digit taken from the low end of the multiplier
  always_comb begin
    case (p_r[1:0])
      2'd0:    part = '0;
      2'd1:    part = {2'b00, a_r};
      2'd2:    part = {1'b0, a_r, 1'b0};
      default: part = {2'b00, a_r} + {1'b0, a_r, 1'b0};
    endcase
    sum   = {2'b00, p_r[A_W+B_W-1:B_W]} + part;
    p_nxt = {sum, p_r[B_W-1:2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{A_W{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = p_r;

endmodule

>>> rtl/lbcg_serial_div.sv
module lbcg_serial_div import lbcg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DT_W-1:0]       dt,
  input  logic [HALF_W-1:0]     divisor,
  output logic                  busy,
  output logic [PHASE_BITS-1:0] quo
);

  localparam int DV_W  = DT_W + PHASE_BITS - 1;
  localparam int CNT_W = $clog2(DV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DV_W - 1);

  logic [DV_W-1:0]       num_r;
  logic [HALF_W-1:0]     div_r;
  logic [HALF_W-1:0]     rem_r;
  logic [PHASE_BITS-1:0] q_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic [HALF_W:0]       trial;
  logic [HALF_W+1:0]     diff;
  logic                  fits;

  // One restoring step per cycle; only the low quotient bits are kept
  always_comb begin
    trial = {rem_r, num_r[DV_W-1]};
    diff  = {1'b0, trial} - {2'b00, div_r};
    fits  = !diff[HALF_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {dt, {(PHASE_BITS-1){1'b0}}};
      div_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DV_W-2:0], 1'b0};
      rem_r <= fits ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
      q_r   <= {q_r[PHASE_BITS-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

>>> rtl/lbcg_ease.sv
module lbcg_ease import lbcg_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [PHASE_BITS-1:0] phase,
  output logic [EASE_W-1:0]     ease
);

  localparam int KB = COS_TABLE_BITS + 2;
  localparam int N  = 1 << COS_TABLE_BITS;

  logic [MAG_W-1:0]          rom_c [N+1];
  logic [PHASE_BITS+KB-1:0]  wide;
  logic [KB-1:0]             k;
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-1:0] j;
  logic [COS_TABLE_BITS:0]   idx;
  logic                      neg;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic [MAG_W:0]            sum;

  for (genvar g = 0; g <= N; g++) begin : g_rom
    localparam logic [MAG_W-1:0] ENTRY = quarter_sine(g, COS_TABLE_BITS);
    assign rom_c[g] = ENTRY;
  end

  // Fold the quadrant onto the quarter-wave table
  always_comb begin
    wide = {phase, {KB{1'b0}}};
    k    = wide[PHASE_BITS+KB-1 -: KB];
    quad = k[KB-1 -: 2];
    j    = k[COS_TABLE_BITS-1:0];
    idx  = quad[0] ? {1'b0, j} : ((COS_TABLE_BITS+1)'(N) - {1'b0, j});
    neg  = quad[0] ^ quad[1];
  end

  always_ff @(posedge clk) begin
    mag_r <= rom_c[idx];
    neg_r <= neg;
  end

  always_comb begin
    sum  = neg_r ? (18'd65536 + {1'b0, mag_r}) : (18'd65536 - {1'b0, mag_r});
    ease = sum[MAG_W] ? {EASE_W{1'b1}} : sum[EASE_W:1];
  end

endmodule

>>> rtl/led_breathing_color_generator_unit.sv
// LED breathing color generator.
// Requests arrive on in_ch carrying a free-running millisecond stamp now_ms.
// While run_enable is set and at least interval_ms have passed (modulo 2^16)
// since the last update, a request yields one result on out_ch: the base
// color scaled by a raised-cosine, gamma-3 brightness between the two levels,
// plus that level. Other requests are taken and dropped.
// An updating request runs one serial 16x16 multiplier, two bits per cycle,
// through three products back to back, then three 8x8 color lanes. The phase
// divider, one quotient bit per cycle over 15 + PHASE_BITS steps, runs in
// parallel and is hidden behind the multiplier chain.
// One request is in flight at a time; in_ch.ready is high only when idle.
// The result sits in an output register; a stalled receiver holds it, and
// the next result waits until that register frees up.
// Reset (synchronous, rst_n low) restores the register defaults, zeroes the
// phase and last update time and empties the output register.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do so while idle (not enforced).
module led_breathing_color_generator_unit import lbcg_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lbcg_stream_if.sink          in_ch,
  lbcg_stream_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [HALF_W-1:0]  half_r;
  logic [LEVEL_W-1:0] lvl_a_r;
  logic [LEVEL_W-1:0] lvl_b_r;
  logic [LEVEL_W-1:0] red_r;
  logic [LEVEL_W-1:0] green_r;
  logic [LEVEL_W-1:0] blue_r;
  logic               run_r;
  logic [IVAL_W-1:0]  ival_r;

  // Block state
  state_t                state_r, state_nxt;
  logic [NOW_W-1:0]      last_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [EASE_W-1:0]     e_r;
  logic [LEVEL_W-1:0]    br_r;
  logic                  out_valid_r;
  out_res_t              out_data_r;

  // Datapath nets
  logic [DT_W-1:0]       dt;
  logic                  too_soon;
  logic                  accept;
  logic                  take;
  logic [HALF_W-1:0]     half_clamp;
  logic [LEVEL_W-1:0]    lo, hi, span;
  logic [EASE_W-1:0]     ease;
  logic [2*EASE_W-1:0]   prod;
  logic                  mul_busy;
  logic [PHASE_BITS-1:0] quo;
  logic                  div_busy;
  logic [2*LEVEL_W-1:0]  red_p, green_p, blue_p;
  logic                  red_busy, green_busy, blue_busy;
  logic                  color_busy;
  logic [24:0]           rnd;
  logic [LEVEL_W:0]      lvl_sum;
  logic [LEVEL_W-1:0]    br_nxt;
  logic                  out_free;

  // FSM outputs
  logic                  in_ready;
  logic                  mul_start;
  logic [EASE_W-1:0]     mul_a, mul_b;
  logic                  e_load;
  logic                  br_load;
  logic                  color_start;
  logic                  out_load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= HALF_RST;
      lvl_a_r <= LVL_A_RST;
      lvl_b_r <= LVL_B_RST;
      red_r   <= BASE_RST;
      green_r <= BASE_RST;
      blue_r  <= BASE_RST;
      run_r   <= 1'b0;
      ival_r  <= IVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_PERIOD: half_r  <= cfg_wdata[HALF_W-1:0];
        REG_LEVEL_A:     lvl_a_r <= cfg_wdata[LEVEL_W-1:0];
        REG_LEVEL_B:     lvl_b_r <= cfg_wdata[LEVEL_W-1:0];
        REG_BASE_RED:    red_r   <= cfg_wdata[LEVEL_W-1:0];
        REG_BASE_GREEN:  green_r <= cfg_wdata[LEVEL_W-1:0];
        REG_BASE_BLUE:   blue_r  <= cfg_wdata[LEVEL_W-1:0];
        REG_RUN_ENABLE:  run_r   <= cfg_wdata[0];
        REG_INTERVAL:    ival_r  <= cfg_wdata[IVAL_W-1:0];
        default:         ;
      endcase
    end
  end

  // Gate the request: elapsed time modulo 2^16 against the interval
  always_comb begin
    dt         = in_ch.data.now_ms[DT_W-1:0] - last_r[DT_W-1:0];
    too_soon   = dt < {{(DT_W-IVAL_W){1'b0}}, ival_r};
    accept     = in_ch.valid && in_ready;
    take       = accept && run_r && !too_soon;
    half_clamp = (half_r < HALF_MIN) ? HALF_MIN :
                 (half_r > HALF_MAX) ? HALF_MAX : half_r;
    lo         = (lvl_a_r < lvl_b_r) ? lvl_a_r : lvl_b_r;
    hi         = (lvl_a_r < lvl_b_r) ? lvl_b_r : lvl_a_r;
    span       = hi - lo;
    color_busy = red_busy || green_busy || blue_busy;
    out_free   = !out_valid_r || out_ch.ready;
  end

  // Level = lo + round(e^3 * span / 2^16)
  always_comb begin
    rnd     = {1'b0, prod[23:0]} + 25'd32768;
    lvl_sum = {1'b0, lo} + {1'b0, rnd[23:16]};
    br_nxt  = lvl_sum[LEVEL_W] ? LEVEL_TOP : lvl_sum[LEVEL_W-1:0];
  end

  lbcg_ease #(
    .PHASE_BITS     (PHASE_BITS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_ease (
    .clk   (clk),
    .phase (phase_r),
    .ease  (ease)
  );

  // Shared multiplier: e*e, then (e*e >> 16)*e, then e^3*span
  lbcg_serial_mul #(
    .A_W (EASE_W),
    .B_W (EASE_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // Phase increment = (dt << (PHASE_BITS-1)) / half, started on the request
  lbcg_serial_div #(
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (take),
    .dt      (dt),
    .divisor (half_clamp),
    .busy    (div_busy),
    .quo     (quo)
  );

  lbcg_serial_mul #(
    .A_W (LEVEL_W),
    .B_W (LEVEL_W)
  ) u_mul_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (color_start),
    .a     (red_r),
    .b     (br_r),
    .busy  (red_busy),
    .prod  (red_p)
  );

  lbcg_serial_mul #(
    .A_W (LEVEL_W),
    .B_W (LEVEL_W)
  ) u_mul_green (
    .clk   (clk),
    .rst_n (rst_n),
    .start (color_start),
    .a     (green_r),
    .b     (br_r),
    .busy  (green_busy),
    .prod  (green_p)
  );

  lbcg_serial_mul #(
    .A_W (LEVEL_W),
    .B_W (LEVEL_W)
  ) u_mul_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .start (color_start),
    .a     (blue_r),
    .b     (br_r),
    .busy  (blue_busy),
    .prod  (blue_p)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (take) state_nxt = ST_EASE;
      ST_EASE:     state_nxt = ST_SQUARE;
      ST_SQUARE:   if (!mul_busy) state_nxt = ST_CUBE;
      ST_CUBE:     if (!mul_busy) state_nxt = ST_SPAN;
      ST_SPAN:     if (!mul_busy) state_nxt = ST_COLOR_GO;
      ST_COLOR_GO: state_nxt = ST_COLOR;
      ST_COLOR:    if (!color_busy) state_nxt = ST_FINISH;
      ST_FINISH:   if (!div_busy && out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready    = 1'b0;
    mul_start   = 1'b0;
    mul_a       = ease;
    mul_b       = ease;
    e_load      = 1'b0;
    br_load     = 1'b0;
    color_start = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EASE: begin
        e_load    = 1'b1;
        mul_start = 1'b1;
      end
      ST_SQUARE: begin
        mul_a     = prod[2*EASE_W-1:EASE_W];
        mul_b     = e_r;
        mul_start = !mul_busy;
      end
      ST_CUBE: begin
        mul_a     = prod[2*EASE_W-1:EASE_W];
        mul_b     = {{(EASE_W-LEVEL_W){1'b0}}, span};
        mul_start = !mul_busy;
      end
      ST_SPAN:     br_load = !mul_busy;
      ST_COLOR_GO: color_start = 1'b1;
      ST_COLOR:    ;
      ST_FINISH:   out_load = !div_busy && out_free;
      default:     ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) last_r <= in_ch.data.now_ms;
      if (out_load) begin
        phase_r     <= phase_r + quo;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (e_load) e_r <= ease;
    if (br_load) br_r <= br_nxt;
    if (out_load) begin
      out_data_r.out_red   <= div255(red_p);
      out_data_r.out_green <= div255(green_p);
      out_data_r.out_blue  <= div255(blue_p);
      out_data_r.level     <= br_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule
